[hdl/yrp_pkg.sv]
// Package for the YUYV to RGB pair converter: payload structs, fixed-point
// coefficients, stage control structs and the clamp function.
// Depends on nothing.
package yrp_pkg;

	localparam int COEF_FRAC_BITS = 10;

	// Signed widths: coefficients stay below 4.0, luma and chroma deltas fit 9 bits.
	localparam int COEF_W  = COEF_FRAC_BITS + 3;
	localparam int DELTA_W = 9;
	localparam int PROD_W  = COEF_W + DELTA_W;
	localparam int SUM_W   = PROD_W + 2;

	localparam int K_Y_I  = ((1164 << COEF_FRAC_BITS) + 500) / 1000;
	localparam int K_VR_I = ((1596 << COEF_FRAC_BITS) + 500) / 1000;
	localparam int K_VG_I = ((813 << COEF_FRAC_BITS) + 500) / 1000;
	localparam int K_UG_I = ((391 << COEF_FRAC_BITS) + 500) / 1000;
	localparam int K_UB_I = ((2018 << COEF_FRAC_BITS) + 500) / 1000;

	localparam logic signed [COEF_W-1:0] K_Y  = COEF_W'(K_Y_I);
	localparam logic signed [COEF_W-1:0] K_VR = COEF_W'(K_VR_I);
	localparam logic signed [COEF_W-1:0] K_VG = COEF_W'(K_VG_I);
	localparam logic signed [COEF_W-1:0] K_UG = COEF_W'(K_UG_I);
	localparam logic signed [COEF_W-1:0] K_UB = COEF_W'(K_UB_I);

	localparam logic signed [DELTA_W-1:0] LUMA_OFS   = 9'sd16;
	localparam logic signed [DELTA_W-1:0] CHROMA_OFS = 9'sd128;

	localparam logic [7:0] BYTE_MAX = 8'hff;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] chroma_blue;
		logic [7:0] luma_second;
		logic [7:0] chroma_red;
	} yuyv_word_t;

	typedef struct packed {
		logic [7:0] red_first;
		logic [7:0] green_first;
		logic [7:0] blue_first;
		logic [7:0] red_second;
		logic [7:0] green_second;
		logic [7:0] blue_second;
	} rgb_pair_t;

	// Load enables for the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Occupancy of the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_vld_t;

	// Floor shift (arithmetic) followed by a clamp to 0..255.
	function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] q;
		logic [7:0] r;
		q = s >>> COEF_FRAC_BITS;
		if (q[SUM_W-1]) begin
			r = 8'h00;
		end else if (|q[SUM_W-2:8]) begin
			r = BYTE_MAX;
		end else begin
			r = q[7:0];
		end
		return r;
	endfunction

endpackage

[hdl/yuyv_to_rgba_pair.sv]
// Top level of the YUYV macropixel to RGB pair converter (BT.601 video range).
// Depends on yrp_pkg, yrp_ctrl, yrp_product and yrp_combine.
//
//   channel   valid / ready          word
//   input     pix_valid / pix_ready  pix_word  (yuyv_word_t: Y0, U, Y1, V)
//   output    rgb_valid / rgb_ready  rgb_word  (rgb_pair_t: two RGB pixels)
//
// Four register stages: offsets, products, channel sums, clamp into the output
// register. An accepted word moves through the stages in that order into the
// output register, and one word is taken every cycle while the output is taken.
// Reset clears the stage valid bits only; the data registers hold no reset.
// A stall at the output holds each full stage with no gap after it; gaps still fill.
module yuyv_to_rgba_pair import yrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  yuyv_word_t pix_word,
	output logic       rgb_valid,
	input  logic       rgb_ready,
	output rgb_pair_t  rgb_word
);

	stage_en_t               en;
	stage_vld_t              vld;
	logic signed [PROD_W-1:0] ly_first_s2, ly_second_s2, vr_s2, vg_s2, ug_s2, ub_s2;

	yrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.en        (en),
		.vld       (vld)
	);

	yrp_product u_product (
		.clk          (clk),
		.en           (en),
		.pix_word     (pix_word),
		.ly_first_s2  (ly_first_s2),
		.ly_second_s2 (ly_second_s2),
		.vr_s2        (vr_s2),
		.vg_s2        (vg_s2),
		.ug_s2        (ug_s2),
		.ub_s2        (ub_s2)
	);

	yrp_combine u_combine (
		.clk          (clk),
		.en           (en),
		.ly_first_s2  (ly_first_s2),
		.ly_second_s2 (ly_second_s2),
		.vr_s2        (vr_s2),
		.vg_s2        (vg_s2),
		.ug_s2        (ug_s2),
		.ub_s2        (ub_s2),
		.rgb_word     (rgb_word)
	);

	// A ready output lets the whole pipeline move.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_ready |-> pix_ready)
		else $error("input stalled while output was ready");

	// The input only stalls when every stage is full and the output is held.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (vld.s1 && vld.s2 && vld.s3 && vld.s4 && !rgb_ready))
		else $error("input stalled with an empty stage");

	// An accepted word occupies the first stage on the next cycle.
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) |=> vld.s1)
		else $error("accepted word not captured");

	// A held output word stays valid and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld.s4 && !rgb_ready) |=> (vld.s4 && $stable(rgb_word)))
		else $error("held stage lost its word");

endmodule

[hdl/yrp_ctrl.sv]
// Stage control for the converter pipeline: valid bits and load enables.
// Depends on yrp_pkg.
module yrp_ctrl import yrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	output logic       rgb_valid,
	input  logic       rgb_ready,
	output stage_en_t  en,
	output stage_vld_t vld
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// A stage loads when it is empty or its content moves on this cycle.
	always_comb begin
		en.s4 = !vld_s4 || rgb_ready;
		en.s3 = !vld_s3 || en.s4;
		en.s2 = !vld_s2 || en.s3;
		en.s1 = !vld_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= pix_valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
		end
	end

	assign pix_ready = en.s1;
	assign rgb_valid = vld_s4;
	assign vld       = '{s1: vld_s1, s2: vld_s2, s3: vld_s3, s4: vld_s4};

endmodule

[hdl/yrp_product.sv]
// Front half of the converter: offset removal, then the six coefficient products.
// Depends on yrp_pkg.
module yrp_product import yrp_pkg::*; (
	input  logic                     clk,
	input  stage_en_t                en,
	input  yuyv_word_t               pix_word,
	output logic signed [PROD_W-1:0] ly_first_s2,
	output logic signed [PROD_W-1:0] ly_second_s2,
	output logic signed [PROD_W-1:0] vr_s2,
	output logic signed [PROD_W-1:0] vg_s2,
	output logic signed [PROD_W-1:0] ug_s2,
	output logic signed [PROD_W-1:0] ub_s2
);

	logic signed [DELTA_W-1:0] yd_first_s1, yd_second_s1, ud_s1, vd_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			yd_first_s1  <= $signed({1'b0, pix_word.luma_first}) - LUMA_OFS;
			yd_second_s1 <= $signed({1'b0, pix_word.luma_second}) - LUMA_OFS;
			ud_s1        <= $signed({1'b0, pix_word.chroma_blue}) - CHROMA_OFS;
			vd_s1        <= $signed({1'b0, pix_word.chroma_red}) - CHROMA_OFS;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ly_first_s2  <= PROD_W'(K_Y) * PROD_W'(yd_first_s1);
			ly_second_s2 <= PROD_W'(K_Y) * PROD_W'(yd_second_s1);
			vr_s2        <= PROD_W'(K_VR) * PROD_W'(vd_s1);
			vg_s2        <= PROD_W'(K_VG) * PROD_W'(vd_s1);
			ug_s2        <= PROD_W'(K_UG) * PROD_W'(ud_s1);
			ub_s2        <= PROD_W'(K_UB) * PROD_W'(ud_s1);
		end
	end

endmodule

[hdl/yrp_combine.sv]
// Back half of the converter: channel sums, then shift, clamp and output register.
// Depends on yrp_pkg.
module yrp_combine import yrp_pkg::*; (
	input  logic                     clk,
	input  stage_en_t                en,
	input  logic signed [PROD_W-1:0] ly_first_s2,
	input  logic signed [PROD_W-1:0] ly_second_s2,
	input  logic signed [PROD_W-1:0] vr_s2,
	input  logic signed [PROD_W-1:0] vg_s2,
	input  logic signed [PROD_W-1:0] ug_s2,
	input  logic signed [PROD_W-1:0] ub_s2,
	output rgb_pair_t                rgb_word
);

	logic signed [SUM_W-1:0] r_first_s3, g_first_s3, b_first_s3;
	logic signed [SUM_W-1:0] r_second_s3, g_second_s3, b_second_s3;
	logic signed [SUM_W-1:0] ly1, ly2, vr, vg, ug, ub;
	rgb_pair_t               rgb_s4;

	assign ly1 = SUM_W'(ly_first_s2);
	assign ly2 = SUM_W'(ly_second_s2);
	assign vr  = SUM_W'(vr_s2);
	assign vg  = SUM_W'(vg_s2);
	assign ug  = SUM_W'(ug_s2);
	assign ub  = SUM_W'(ub_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			r_first_s3  <= ly1 + vr;
			g_first_s3  <= ly1 - vg - ug;
			b_first_s3  <= ly1 + ub;
			r_second_s3 <= ly2 + vr;
			g_second_s3 <= ly2 - vg - ug;
			b_second_s3 <= ly2 + ub;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			rgb_s4.red_first    <= clamp_byte(r_first_s3);
			rgb_s4.green_first  <= clamp_byte(g_first_s3);
			rgb_s4.blue_first   <= clamp_byte(b_first_s3);
			rgb_s4.red_second   <= clamp_byte(r_second_s3);
			rgb_s4.green_second <= clamp_byte(g_second_s3);
			rgb_s4.blue_second  <= clamp_byte(b_second_s3);
		end
	end

	assign rgb_word = rgb_s4;

endmodule
